// ===== src/bfu_pkg.sv =====
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared types and constants of the bit-field unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package bfu_pkg;

	localparam int BYTE_W      = 8;
	localparam int ELEM_MIN    = 8;
	localparam int ELEM_MAX    = 25;
	localparam int PAD_MAX     = 4;
	localparam int HELD_W      = 6;
	localparam int EBITS_W     = 5;
	localparam int PAD_W       = 3;
	localparam int NBYTES_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTES    = 1'd1;

	localparam logic [EBITS_W-1:0] ELEMENT_BITS_RST = 5'd20;
	localparam logic [PAD_W-1:0]   PAD_BYTES_RST    = 3'd0;

	// one finished element with its framing
	typedef struct packed {
		logic [ELEM_MAX-1:0] value;
		logic [PAD_W-1:0]    pad;
		logic [NBYTES_W-1:0] nbytes;
	} elem_t;

endpackage

`default_nettype wire

// ===== src/bfu_serializer.sv =====
// ----------------------------------------------------------------------------
// bfu_serializer
// Holds one finished element and plays elements out one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bfu_serializer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire bfu_pkg::elem_t            elem,
	output logic                           hold_full,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [bfu_pkg::BYTE_W-1:0]     m_axis_tdata,   // out_byte
	output logic                           m_axis_tlast    // element_done
);

	logic                            hold_valid_q;
	bfu_pkg::elem_t                  hold_q;
	logic                            active_q;
	logic [bfu_pkg::ELEM_MAX-1:0]    cur_q;
	logic [bfu_pkg::PAD_W-1:0]       pad_left_q;
	logic [bfu_pkg::NBYTES_W-1:0]    byte_left_q;
	logic                            fire;
	logic                            last_fire;
	logic                            load;
	logic [bfu_pkg::BYTE_W-1:0]      data_byte;

	// the slot can take a new element in the cycle its current one moves out
	assign hold_full     = hold_valid_q && !load;
	assign m_axis_tvalid = active_q;
	assign fire          = active_q && m_axis_tready;
	assign m_axis_tlast  = (pad_left_q == '0) && (byte_left_q == 3'd1);
	assign last_fire     = fire && m_axis_tlast;
	assign load          = hold_valid_q && (!active_q || last_fire);

	// big-endian byte pick, byte_left counts down to the least significant byte
	always_comb begin
		case (byte_left_q)
			3'd1:    data_byte = cur_q[7:0];
			3'd2:    data_byte = cur_q[15:8];
			3'd3:    data_byte = cur_q[23:16];
			3'd4:    data_byte = {7'd0, cur_q[24]};
			default: data_byte = '0;
		endcase
	end

	assign m_axis_tdata = (pad_left_q != '0) ? '0 : data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			active_q     <= 1'b0;
			pad_left_q   <= '0;
			byte_left_q  <= '0;
		end else begin
			if (push) begin
				hold_valid_q <= 1'b1;
			end else if (load) begin
				hold_valid_q <= 1'b0;
			end
			if (load) begin
				active_q    <= 1'b1;
				pad_left_q  <= hold_q.pad;
				byte_left_q <= hold_q.nbytes;
			end else if (last_fire) begin
				active_q <= 1'b0;
			end else if (fire) begin
				if (pad_left_q != '0) begin
					pad_left_q <= pad_left_q - 3'd1;
				end else begin
					byte_left_q <= byte_left_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= elem;
		end
		if (load) begin
			cur_q <= hold_q.value;
		end
	end

endmodule

`default_nettype wire

// ===== src/bit_field_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// bit_field_unpacker_core
// Unpacks an MSB-first byte stream into fixed-width elements, each sent out
// as padding zero bytes followed by its big-endian data bytes.
// ----------------------------------------------------------------------------
// output path: the element completed by an input byte is registered in the hold
//   slot, then loaded into the serializer when it is free, which presents its first byte
// throughput: one input byte per cycle; each element then occupies the output
//   for its clamped pad_bytes plus ceil(element_bits/8) byte transactions;
//   input stalls only while an element waits behind a busy serializer
// reset: accumulator and held-bit count clear, element_bits = 20, pad_bytes = 0
`default_nettype none

module bit_field_unpacker_core #(
	parameter int ACC_WIDTH = 32    // accumulator width, 16..64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bfu_pkg::CFG_DATA_W-1:0] cfg_data,
	// input byte stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [bfu_pkg::BYTE_W-1:0]    s_axis_tdata,   // data_byte
	input  wire logic                          s_axis_tuser,   // start_of_array
	// output byte stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [bfu_pkg::BYTE_W-1:0]         m_axis_tdata,   // out_byte
	output logic                               m_axis_tlast    // element_done
);

	// widest element the accumulator can hold next to a fresh byte
	localparam int ELEM_HI = (ACC_WIDTH - 7 < bfu_pkg::ELEM_MAX) ?
		(ACC_WIDTH - 7) : bfu_pkg::ELEM_MAX;
	// shifter width, at least as wide as an element
	localparam int SH_W = (ACC_WIDTH > bfu_pkg::ELEM_MAX) ? ACC_WIDTH : bfu_pkg::ELEM_MAX;

	// configuration registers
	logic [bfu_pkg::EBITS_W-1:0]  element_bits_q;
	logic [bfu_pkg::PAD_W-1:0]    pad_bytes_q;

	// stream state
	logic [ACC_WIDTH-1:0]         acc_q;
	logic [bfu_pkg::HELD_W-1:0]   held_q;

	logic                         in_fire;
	logic                         hold_full;
	logic [bfu_pkg::EBITS_W-1:0]  bits_eff;
	logic [bfu_pkg::PAD_W-1:0]    pad_eff;
	logic [ACC_WIDTH-1:0]         acc_base;
	logic [ACC_WIDTH-1:0]         acc_next;
	logic [bfu_pkg::HELD_W-1:0]   held_sum;
	logic [bfu_pkg::HELD_W-1:0]   held_after;
	logic                         emit;
	logic [SH_W-1:0]              shifted;
	logic [bfu_pkg::ELEM_MAX-1:0] emask;
	logic [bfu_pkg::HELD_W-1:0]   bits_round;
	bfu_pkg::elem_t               elem;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_bits_q <= bfu_pkg::ELEMENT_BITS_RST;
			pad_bytes_q    <= bfu_pkg::PAD_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bfu_pkg::REG_ELEMENT_BITS: element_bits_q <= cfg_data;
				bfu_pkg::REG_PAD_BYTES:    pad_bytes_q    <= cfg_data[bfu_pkg::PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the registers to the usable ranges
	always_comb begin
		bits_eff = element_bits_q;
		if (bits_eff < bfu_pkg::EBITS_W'(bfu_pkg::ELEM_MIN)) begin
			bits_eff = bfu_pkg::EBITS_W'(bfu_pkg::ELEM_MIN);
		end
		if (bits_eff > bfu_pkg::EBITS_W'(ELEM_HI)) begin
			bits_eff = bfu_pkg::EBITS_W'(ELEM_HI);
		end
		pad_eff = (pad_bytes_q > bfu_pkg::PAD_W'(bfu_pkg::PAD_MAX)) ?
			bfu_pkg::PAD_W'(bfu_pkg::PAD_MAX) : pad_bytes_q;
	end

	// the result slot must be free, since any byte may complete an element
	assign s_axis_tready = !hold_full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// shift the new byte into the low end; start of array drops old bits first
	assign acc_base = s_axis_tuser ? '0 : acc_q;
	assign acc_next = {acc_base[ACC_WIDTH-bfu_pkg::BYTE_W-1:0], s_axis_tdata};
	assign held_sum = (s_axis_tuser ? '0 : held_q) + bfu_pkg::HELD_W'(bfu_pkg::BYTE_W);
	assign emit     = held_sum >= bfu_pkg::HELD_W'(bits_eff);
	assign held_after = held_sum - bfu_pkg::HELD_W'(bits_eff);

	// oldest element_bits held bits sit just above the bits still held
	assign shifted = SH_W'(acc_next) >> held_after;
	// a full 25-bit width wraps the shift to zero, giving all ones
	assign emask   = (bfu_pkg::ELEM_MAX'(1) << bits_eff) - bfu_pkg::ELEM_MAX'(1);
	assign bits_round = bfu_pkg::HELD_W'(bits_eff) + 6'd7;

	always_comb begin
		elem.value  = shifted[bfu_pkg::ELEM_MAX-1:0] & emask;
		elem.pad    = pad_eff;
		elem.nbytes = bits_round[bfu_pkg::HELD_W-1:3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (in_fire) begin
			acc_q  <= acc_next;
			held_q <= emit ? held_after : held_sum;
		end
	end

	// element slot and byte-wide output
	bfu_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (in_fire && emit),
		.elem          (elem),
		.hold_full     (hold_full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== tb/bit_field_unpacker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_unpacker_core_test
// Self-checking bench for the bit-field unpacker. Bytes go in on the input
// stream and an element predictor tracks the accumulator and held-bit count.
// Every output transaction is checked against the oldest predicted byte.
// A directed part covers width and padding extremes, out-of-range register
// values, start flags and register changes mid-stream. Random phases follow
// with varied settings and random idling on both streams.
// ----------------------------------------------------------------------------

module bit_field_unpacker_core_test;

	localparam int ACC_W       = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;    // cycles after the last byte before a register write
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 56;

	// element predictor and queue of predicted output bytes
	class unpack_scoreboard;
		typedef struct packed {
			logic [bfu_pkg::BYTE_W-1:0] data;
			logic                       done;
		} out_byte_t;

		logic [bfu_pkg::EBITS_W-1:0] element_bits;
		logic [bfu_pkg::PAD_W-1:0]   pad_bytes;
		logic [63:0]                 acc;
		logic [bfu_pkg::HELD_W-1:0]  held;
		out_byte_t                   predicted_q[$];
		int                          fails;

		function new();
			element_bits = bfu_pkg::ELEMENT_BITS_RST;
			pad_bytes    = bfu_pkg::PAD_BYTES_RST;
			acc          = '0;
			held         = '0;
			fails        = 0;
		endfunction

		function void write_reg(logic [bfu_pkg::CFG_IDX_W-1:0] idx,
			logic [bfu_pkg::CFG_DATA_W-1:0] value);
			if (idx == bfu_pkg::REG_ELEMENT_BITS) begin
				element_bits = value[bfu_pkg::EBITS_W-1:0];
			end else if (idx == bfu_pkg::REG_PAD_BYTES) begin
				pad_bytes = value[bfu_pkg::PAD_W-1:0];
			end
		endfunction

		// takes one accepted input byte and queues the bytes of any element it finishes
		function void note_byte(logic [bfu_pkg::BYTE_W-1:0] d, logic start);
			int          width;
			int          limit;
			int          pad;
			int          nbytes;
			int          up;
			logic [63:0] emask;
			logic [63:0] v;
			logic [63:0] acc_mask;
			out_byte_t   ob;

			limit = (ACC_W - 7 < bfu_pkg::ELEM_MAX) ? ACC_W - 7 : bfu_pkg::ELEM_MAX;
			width = int'(element_bits);
			if (width < bfu_pkg::ELEM_MIN) width = bfu_pkg::ELEM_MIN;
			if (width > limit) width = limit;
			pad = (int'(pad_bytes) > bfu_pkg::PAD_MAX) ? bfu_pkg::PAD_MAX : int'(pad_bytes);
			acc_mask = {64{1'b1}} >> (64 - ACC_W);

			if (start) begin
				acc  = '0;
				held = '0;
			end
			acc  = ((acc << bfu_pkg::BYTE_W) | {56'd0, d}) & acc_mask;
			held = held + bfu_pkg::HELD_W'(bfu_pkg::BYTE_W);
			if (int'(held) < width) return;

			held   = held - bfu_pkg::HELD_W'(width);
			nbytes = (width + 7) / bfu_pkg::BYTE_W;
			emask  = (64'd1 << width) - 64'd1;
			for (int k = 0; k < pad; k++) begin
				ob.data = '0;
				ob.done = 1'b0;
				predicted_q.push_back(ob);
			end
			// big-endian: most significant data byte first, masked to the element width
			for (int k = 0; k < nbytes; k++) begin
				up = bfu_pkg::BYTE_W * (nbytes - 1 - k);
				v  = (acc >> (int'(held) + up)) & ((emask >> up) & 64'hFF);
				ob.data = v[bfu_pkg::BYTE_W-1:0];
				ob.done = (k == nbytes - 1);
				predicted_q.push_back(ob);
			end
		endfunction

		function void check_byte(logic [bfu_pkg::BYTE_W-1:0] d, logic done);
			out_byte_t want;
			if (predicted_q.size() == 0) begin
				$display("%0t: unexpected output byte, actual data %h last %b", $time, d, done);
				fails++;
				return;
			end
			want = predicted_q.pop_front();
			if (d !== want.data) begin
				$display("%0t: output data mismatch, expected %h actual %h", $time, want.data, d);
				fails++;
			end
			if (done !== want.done) begin
				$display("%0t: output last mismatch, expected %b actual %b", $time, want.done,
					done);
				fails++;
			end
		endfunction

		function int pending();
			return predicted_q.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [bfu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bfu_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [bfu_pkg::BYTE_W-1:0]     s_axis_tdata;   // data_byte
	logic                           s_axis_tuser;   // start_of_array
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [bfu_pkg::BYTE_W-1:0]     m_axis_tdata;   // out_byte
	logic                           m_axis_tlast;   // element_done

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          cycle_count    = 0;

	unpack_scoreboard sb = new();

	bit_field_unpacker_core #(
		.ACC_WIDTH(ACC_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random back-pressure, changed at the falling edge
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// output transactions are checked at the rising edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("bit_field_unpacker_core_test: FAIL");
		$finish;
	end

	// all tasks start and end at a falling edge
	task automatic send_byte(input logic [bfu_pkg::BYTE_W-1:0] d, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(d, start);
		@(negedge clk);
	endtask

	// waits out every predicted byte, then lets the pipeline settle
	task automatic drain_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_config(input logic [bfu_pkg::CFG_DATA_W-1:0] ebits,
		input logic [bfu_pkg::CFG_DATA_W-1:0] pad_data);
		cfg_valid <= 1'b1;
		cfg_index <= bfu_pkg::REG_ELEMENT_BITS;
		cfg_data  <= ebits;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(bfu_pkg::REG_ELEMENT_BITS, ebits);
		@(negedge clk);
		cfg_index <= bfu_pkg::REG_PAD_BYTES;
		cfg_data  <= pad_data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(bfu_pkg::REG_PAD_BYTES, pad_data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// idling modes: none, sender gaps, receiver stalls, both
	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				send_idle_pct  = 79;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 79;
			end
			3: begin
				send_idle_pct  = 23;
				recv_stall_pct = 23;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		int unsigned                    rnd;
		logic [bfu_pkg::CFG_DATA_W-1:0] ebits;
		logic [bfu_pkg::CFG_DATA_W-1:0] pad_data;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: 20-bit elements, no padding
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		drain_idle();

		// narrowest element with the most padding
		write_config(5'd8, 5'd4);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		drain_idle();

		// width and padding above range clamp; accumulator overflows
		write_config(5'd31, 5'd7);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7E, 1'b0);
		drain_idle();

		// width below range clamps up; padding above range clamps down
		write_config(5'd0, 5'd5);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		drain_idle();

		// widest element, held bits carried across the register change
		write_config(5'd25, 5'd0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain_idle();
			if (p == 0) begin
				ebits    = 5'd8;
				pad_data = 5'd0;
			end else if (p == 1) begin
				ebits    = 5'd25;
				pad_data = 5'd4;
			end else begin
				rnd      = $urandom;
				ebits    = (rnd[3:0] == 4'd0) ? rnd[8:4] : 5'(8 + (rnd[8:4] % 18));
				pad_data = (rnd[11:10] == 2'd0) ? rnd[16:12] : 5'(rnd[16:12] % 5);
			end
			write_config(ebits, pad_data);
			set_idling(p % 4);
			repeat (PHASE_ITEMS) begin
				rnd = $urandom;
				send_byte(rnd[7:0], rnd[11:8] == 4'd0);
			end
		end

		drain_idle();
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("bit_field_unpacker_core_test: PASS");
		end else begin
			$display("bit_field_unpacker_core_test: FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bfu_pkg.sv
src/bfu_serializer.sv
src/bit_field_unpacker_core.sv
tb/bit_field_unpacker_core_test.sv
